### rtl/mbe_pkg.sv
// Package with the shared types, widths and helper functions of the Mandelbrot iteration block.
package mbe_pkg;

  // Datapath widths: Q4.27 values, full-width products, and sums with headroom.
  localparam int ZW = 32;
  localparam int PW = 64;
  localparam int SW = 66;

  localparam int CNT_W    = 12;
  localparam int COLOUR_W = 22;
  localparam int ZS_W     = 29;
  localparam int STEP_W   = 28;
  localparam int OFF_W    = 12;
  localparam int CFG_W    = 29;
  localparam int REG_IDX_W = 3;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 27;

  // Reset values of the configuration registers.
  localparam logic [ZS_W-1:0]   Z_START_RST    = ZS_W'(10666014);
  localparam logic [STEP_W-1:0] STEP_RST       = STEP_W'(167772);
  localparam logic [OFF_W-1:0]  COL_OFFSET_RST = OFF_W'(600);
  localparam logic [OFF_W-1:0]  ROW_OFFSET_RST = OFF_W'(1100);
  localparam logic [CNT_W-1:0]  ITER_LIMIT_RST = CNT_W'(1024);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_Z_START    = 3'd0,
    REG_STEP       = 3'd1,
    REG_COL_OFFSET = 3'd2,
    REG_ROW_OFFSET = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } mbe_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRE,
    ST_CIM,
    ST_SQ0,
    ST_SQR,
    ST_SQI,
    ST_TST,
    ST_UPD
  } mbe_state_e;

  typedef enum logic [2:0] {
    MS_CRE,
    MS_CIM,
    MS_RR,
    MS_II,
    MS_RI
  } mbe_mul_sel_e;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    mbe_mul_sel_e mul_sel;
    logic         in_ready;
    logic         load_item;
    logic         load_cre;
    logic         load_cim;
    logic         load_rr;
    logic         test;
    logic         update;
    logic         load_out;
  } mbe_ctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic go_on;
    logic out_free;
    logic done_wait;
  } mbe_sts_t;

  // Clamps a wide signed value to the signed 32-bit range.
  function automatic logic signed [ZW-1:0] sat32(input logic signed [SW-1:0] v);
    logic [SW-ZW:0] top;
    top = v[SW-1:ZW-1];
    if ((&top) || !(|top)) begin
      return v[ZW-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(ZW-1){1'b0}}};
    end else begin
      return {1'b0, {(ZW-1){1'b1}}};
    end
  endfunction

  // Colour value is the count times 1000, done as 1024 - 16 - 8.
  function automatic logic [COLOUR_W-1:0] colour_of(input logic [CNT_W-1:0] c);
    return COLOUR_W'({c, 10'b0}) - COLOUR_W'({c, 4'b0}) - COLOUR_W'({c, 3'b0});
  endfunction

endpackage

### rtl/mbe_mul.sv
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
module mbe_mul
  import mbe_pkg::*;
(
  input  logic                 clk_i,
  input  logic signed [ZW-1:0] a_i,
  input  logic signed [ZW-1:0] b_i,
  output logic signed [PW-1:0] p_o
);

  logic signed [PW-1:0] p_q;
  logic signed [PW-1:0] p_d;

  assign p_d = PW'(a_i) * PW'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

### rtl/mbe_seq.sv
// Sequencer that steps the shared multiplier through the c setup and each iteration.
module mbe_seq
  import mbe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mbe_sts_t sts_i,
  output mbe_ctl_t ctl_o
);

  mbe_state_e state_q;
  mbe_state_e state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.in_valid && !sts_i.done_wait) begin
          state_d = ST_CRE;
        end
      end
      ST_CRE: state_d = ST_CIM;
      ST_CIM: state_d = ST_SQ0;
      ST_SQ0: state_d = ST_SQI;
      ST_SQR: state_d = ST_SQI;
      ST_SQI: state_d = ST_TST;
      ST_TST: begin
        if (sts_i.go_on) begin
          state_d = ST_UPD;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_UPD: state_d = ST_SQR;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    ctl_o.mul_sel = MS_RR;
    case (state_q)
      ST_IDLE: begin
        ctl_o.in_ready  = !sts_i.done_wait;
        ctl_o.load_item = sts_i.in_valid && !sts_i.done_wait;
      end
      ST_CRE: ctl_o.mul_sel = MS_CRE;
      ST_CIM: begin
        ctl_o.mul_sel  = MS_CIM;
        ctl_o.load_cre = 1'b1;
      end
      ST_SQ0: begin
        ctl_o.mul_sel  = MS_RR;
        ctl_o.load_cim = 1'b1;
      end
      ST_SQR: ctl_o.mul_sel = MS_RR;
      ST_SQI: begin
        ctl_o.mul_sel = MS_II;
        ctl_o.load_rr = 1'b1;
      end
      ST_TST: begin
        // While a finished pixel waits for the output, zi*zi is formed again so the
        // escape test keeps seeing the same magnitude.
        ctl_o.mul_sel  = sts_i.go_on ? MS_RI : MS_II;
        ctl_o.test     = 1'b1;
        ctl_o.load_out = !sts_i.go_on && sts_i.out_free;
      end
      ST_UPD: ctl_o.update = 1'b1;
      default: ctl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/mandelbrot_escape_iteration.sv
// Top level of the Mandelbrot escape-time iteration block: registers, datapath and output.
// One pixel item at a time: after acceptance the block forms c and the first squares, then
// runs each iteration as update, two squares with the escape test, and the cross product,
// until the pixel stops; its result then waits, if need be, for the previous result to be
// taken. The single shared 32x32 multiplier is used three times per iteration, and
// in_ready_o is low for the whole time. Configuration registers are written through a
// plain write port and are read live: that a write takes effect for the next accepted
// item is up to the user, as the block itself does not enforce it.
module mandelbrot_escape_iteration
  import mbe_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [COORD_BITS-1:0] column_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] row_out_o,
  output logic [COORD_BITS-1:0] column_out_o,
  output logic [CNT_W-1:0]      iterations_o,
  output logic [COLOUR_W-1:0]   colour_o
);

  localparam logic [PW-1:0] ESC_LIM = PW'(1) << (2 * FRAC_BITS + 2);

  mbe_ctl_t ctl;
  mbe_sts_t sts;

  // Configuration registers.
  logic [ZS_W-1:0]   z_start_q;
  logic [STEP_W-1:0] step_q;
  logic [OFF_W-1:0]  col_offset_q;
  logic [OFF_W-1:0]  row_offset_q;
  logic [CNT_W-1:0]  iter_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_start_q    <= Z_START_RST;
      step_q       <= STEP_RST;
      col_offset_q <= COL_OFFSET_RST;
      row_offset_q <= ROW_OFFSET_RST;
      iter_limit_q <= ITER_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_Z_START:    z_start_q    <= cfg_data_i[ZS_W-1:0];
        REG_STEP:       step_q       <= cfg_data_i[STEP_W-1:0];
        REG_COL_OFFSET: col_offset_q <= cfg_data_i[OFF_W-1:0];
        REG_ROW_OFFSET: row_offset_q <= cfg_data_i[OFF_W-1:0];
        REG_ITER_LIMIT: iter_limit_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers of the current pixel.
  logic [COORD_BITS-1:0] row_q;
  logic [COORD_BITS-1:0] col_q;
  logic signed [ZW-1:0]  zr_q;
  logic signed [ZW-1:0]  zi_q;
  logic signed [ZW-1:0]  cr_q;
  logic signed [ZW-1:0]  ci_q;
  logic signed [PW-1:0]  rr_q;
  logic signed [SW-1:0]  d_q;
  logic [CNT_W-1:0]      count_q;
  logic                  first_q;

  logic signed [PW-1:0]  prod;
  logic signed [ZW-1:0]  mul_a;
  logic signed [ZW-1:0]  mul_b;
  logic signed [OFF_W:0] col_diff;
  logic signed [OFF_W:0] row_diff;
  logic signed [ZW-1:0]  step_x;
  logic signed [ZW-1:0]  zs_x;
  logic [PW-1:0]         lensq;
  logic                  escaped;
  logic signed [SW-1:0]  rr_x;
  logic signed [SW-1:0]  ii_x;
  logic signed [SW-1:0]  ri_x;
  logic signed [SW-1:0]  nr;
  logic signed [SW-1:0]  ni;

  assign col_diff = $signed({1'b0, (OFF_W)'(col_q)}) - $signed({1'b0, col_offset_q});
  assign row_diff = $signed({1'b0, (OFF_W)'(row_q)}) - $signed({1'b0, row_offset_q});
  assign step_x   = $signed(ZW'(step_q));
  assign zs_x     = ZW'($signed(z_start_q));

  always_comb begin
    mul_a = zr_q;
    mul_b = zr_q;
    case (ctl.mul_sel)
      MS_CRE: begin
        mul_a = ZW'(col_diff);
        mul_b = step_x;
      end
      MS_CIM: begin
        mul_a = ZW'(row_diff);
        mul_b = step_x;
      end
      MS_RR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      MS_II: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      MS_RI: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
    endcase
  end

  mbe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // In the test cycle the product holds zi*zi and rr_q holds zr*zr; both are nonnegative.
  assign lensq   = rr_q + prod;
  assign escaped = (lensq >= ESC_LIM);
  assign rr_x    = SW'(rr_q);
  assign ii_x    = SW'(prod);
  assign ri_x    = SW'(prod);

  // Arithmetic shifts round toward minus infinity, as the fixed-point scaling requires.
  assign nr = d_q + SW'(cr_q);
  assign ni = (ri_x >>> (FRAC_BITS - 1)) + SW'(ci_q);

  always_ff @(posedge clk_i) begin
    if (ctl.load_item) begin
      row_q   <= row_i;
      col_q   <= column_i;
      zr_q    <= zs_x;
      zi_q    <= zs_x;
      count_q <= '0;
    end
    if (ctl.load_cre) begin
      cr_q <= sat32(SW'(prod));
    end
    if (ctl.load_cim) begin
      ci_q <= sat32(SW'(prod));
    end
    if (ctl.load_rr) begin
      rr_q <= prod;
    end
    if (ctl.test) begin
      d_q <= (rr_x >>> FRAC_BITS) - (ii_x >>> FRAC_BITS);
    end
    if (ctl.update) begin
      zr_q    <= sat32(nr);
      zi_q    <= sat32(ni);
      count_q <= count_q + CNT_W'(1);
    end
  end

  // The first pass always iterates; the escape test applies from the second on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else if (ctl.load_item) begin
      first_q <= 1'b1;
    end else if (ctl.update) begin
      first_q <= 1'b0;
    end
  end

  // Output register.
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] row_out_q;
  logic [COORD_BITS-1:0] col_out_q;
  logic [CNT_W-1:0]      iter_out_q;
  logic [COLOUR_W-1:0]   colour_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load_out) begin
      row_out_q    <= row_q;
      col_out_q    <= col_q;
      iter_out_q   <= count_q;
      colour_out_q <= colour_of(count_q);
    end
  end

  assign sts.in_valid  = in_valid_i;
  assign sts.go_on     = first_q || (!escaped && (count_q < iter_limit_q));
  assign sts.out_free  = !out_valid_q || out_ready_i;
  assign sts.done_wait = 1'b0;

  mbe_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  assign in_ready_o   = ctl.in_ready;
  assign out_valid_o  = out_valid_q;
  assign row_out_o    = row_out_q;
  assign column_out_o = col_out_q;
  assign iterations_o = iter_out_q;
  assign colour_o     = colour_out_q;

  // Once an item is taken, the block stays busy until its result is formed.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block ready again right after taking an item");

  // Every result reports at least the one mandatory iteration.
  a_iter_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iterations_o != '0)
    else $error("result with zero iterations");

  // The colour always matches the reported count.
  a_colour_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> colour_o == colour_of(iterations_o))
    else $error("colour does not match iteration count");

  // A result is only loaded when the output register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> !out_valid_o || out_ready_i)
    else $error("pending item overwritten");

endmodule
